[rtl/ccfg_pkg.sv]
`timescale 1ns / 1ps

package ccfg_pkg;

    // fixed field widths
    localparam int CODE_W     = 64;
    localparam int SIZE_W     = 16;
    localparam int SW_W       = 5;
    localparam int OFF_W      = 7;
    localparam int CNT_W      = 3;
    localparam int DIMS_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_SLICE  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd1;

    // reset values
    localparam logic [DIMS_W-1:0] DIMS_RST  = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 16'd16;
    localparam logic [SW_W-1:0]   WIDTH_RST = 5'd5;

    typedef struct packed {
        logic [CODE_W-1:0] cube_code;
    } cube_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] facet_code;
        logic              negative_sign;
        logic [CNT_W-1:0]  cube_dimension;
        logic              no_facets;
        logic              last;
    } facet_word_t;

    // item as it travels down the row of cells
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  cnt;
    } item_t;

    // size register write for one cell
    typedef struct packed {
        logic                  we;
        logic [SIZE_W-1:0]     data;
    } cfg_wr_t;

    // slice width: smallest k with 2^k >= size, plus one; 17 when none fits
    function automatic logic [SW_W-1:0] slice_width(input logic [SIZE_W-1:0] size);
        logic [SW_W-1:0] w;
        w = 5'd17;
        for (int k = 15; k >= 0; k--)
        begin
            if ((17'd1 << k) >= {1'b0, size})
            begin
                w = SW_W'(k + 1);
            end
        end
        return w;
    endfunction

endpackage

[rtl/ccfg_if.sv]
`timescale 1ns / 1ps

interface ccfg_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/cubical_cube_facet_generator.sv]
`timescale 1ns / 1ps

// a cube word passes the MAX_DIMS cell registers, then the serialiser's registers
// throughput: one result word per cycle while the output is not stalled; a cube
//   gives two words per extent in a usable slice, a vertex one, set by the serialiser
// the row of cells takes a new cube word every cycle while the serialiser keeps up
// reset: clears all valid flags, dims_in_use back to 2, every grid size back to 16

module cubical_cube_facet_generator #(
    parameter int MAX_DIMS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ccfg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccfg_pkg::CFG_DATA_W-1:0]    cfg_data,
    ccfg_if.sink                               cube_ch,
    ccfg_if.source                             facet_ch
);

    logic [ccfg_pkg::DIMS_W-1:0] dims_reg;
    logic [ccfg_pkg::DIMS_W-1:0] act;
    logic [MAX_DIMS-1:0]         dim_on;
    logic                        adv;
    logic                        tail_take;

    logic                                      stg_v    [MAX_DIMS+1];
    ccfg_pkg::item_t                           stg_item [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0] stg_inc  [MAX_DIMS+1];
    logic [MAX_DIMS-1:0]                       stg_has  [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][ccfg_pkg::OFF_W-1:0]  offs;

    // dimension count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= ccfg_pkg::DIMS_RST;
        end
        else if (cfg_we && cfg_index == ccfg_pkg::CFG_DIMS)
        begin
            dims_reg <= cfg_data[ccfg_pkg::DIMS_W-1:0];
        end
    end

    // dimensions in use, saturated
    always_comb
    begin
        act = (dims_reg > ccfg_pkg::DIMS_W'(MAX_DIMS)) ?
              ccfg_pkg::DIMS_W'(MAX_DIMS) : dims_reg;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            dim_on[d] = ccfg_pkg::DIMS_W'(d) < act;
        end
    end

    // whole row moves when the tail is free or handed over
    assign adv           = !stg_v[MAX_DIMS] || tail_take;
    assign cube_ch.ready = adv;

    assign stg_v[0]         = cube_ch.valid;
    assign stg_item[0].code = cube_ch.data.cube_code;
    assign stg_item[0].cnt  = '0;
    assign stg_inc[0]       = '0;
    assign stg_has[0]       = '0;
    assign offs[0]          = '0;

    // one cell per dimension
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_cell
        ccfg_pkg::cfg_wr_t wr;

        assign wr.we   = cfg_we &&
                         (cfg_index == ccfg_pkg::CFG_SIZE0 + ccfg_pkg::CFG_IDX_W'(d));
        assign wr.data = cfg_data;

        if (d < MAX_DIMS - 1)
        begin : g_mid
            ccfg_cell #(.MAX_DIMS(MAX_DIMS), .IDX(d)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .cfg_wr    (wr),
                .dim_on    (dim_on[d]),
                .off_in    (offs[d]),
                .off_next  (offs[d+1]),
                .in_valid  (stg_v[d]),
                .in_item   (stg_item[d]),
                .in_inc    (stg_inc[d]),
                .in_has    (stg_has[d]),
                .out_valid (stg_v[d+1]),
                .out_item  (stg_item[d+1]),
                .out_inc   (stg_inc[d+1]),
                .out_has   (stg_has[d+1])
            );
        end
        else
        begin : g_end
            ccfg_cell #(.MAX_DIMS(MAX_DIMS), .IDX(d)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .cfg_wr    (wr),
                .dim_on    (dim_on[d]),
                .off_in    (offs[d]),
                .off_next  (),
                .in_valid  (stg_v[d]),
                .in_item   (stg_item[d]),
                .in_inc    (stg_inc[d]),
                .in_has    (stg_has[d]),
                .out_valid (stg_v[d+1]),
                .out_item  (stg_item[d+1]),
                .out_inc   (stg_inc[d+1]),
                .out_has   (stg_has[d+1])
            );
        end
    end

    // facet serialiser and output register
    ccfg_emit #(.MAX_DIMS(MAX_DIMS)) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (stg_v[MAX_DIMS]),
        .tail_item  (stg_item[MAX_DIMS]),
        .tail_inc   (stg_inc[MAX_DIMS]),
        .tail_has   (stg_has[MAX_DIMS]),
        .offs       (offs),
        .tail_take  (tail_take),
        .facet_ch   (facet_ch)
    );

endmodule

[rtl/ccfg_cell.sv]
`timescale 1ns / 1ps

module ccfg_cell #(
    parameter int MAX_DIMS = 4,
    parameter int IDX      = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  ccfg_pkg::cfg_wr_t                             cfg_wr,
    input  logic                                          dim_on,
    input  logic [ccfg_pkg::OFF_W-1:0]                    off_in,
    output logic [ccfg_pkg::OFF_W-1:0]                    off_next,
    input  logic                                          in_valid,
    input  ccfg_pkg::item_t                               in_item,
    input  logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0]     in_inc,
    input  logic [MAX_DIMS-1:0]                           in_has,
    output logic                                          out_valid,
    output ccfg_pkg::item_t                               out_item,
    output logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0]     out_inc,
    output logic [MAX_DIMS-1:0]                           out_has
);

    logic [ccfg_pkg::SIZE_W-1:0] size_reg;
    logic [ccfg_pkg::SW_W-1:0]   width_reg;

    logic                          valid_reg;
    ccfg_pkg::item_t               item_reg;
    logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0] inc_reg;
    logic [MAX_DIMS-1:0]           has_reg;
    logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0] inc_next;
    logic [MAX_DIMS-1:0]           has_next;

    logic [ccfg_pkg::OFF_W-1:0]  off_p1;
    logic [ccfg_pkg::CODE_W-1:0] sh;
    logic [16:0]                 one_w;
    logic [15:0]                 coord;
    logic [16:0]                 x;
    logic [16:0]                 sz;
    logic [15:0]                 inc;
    logic [16:0]                 wmask;
    logic [ccfg_pkg::CODE_W-1:0] fmask;
    logic [ccfg_pkg::CODE_W-1:0] ins;
    logic [ccfg_pkg::CODE_W-1:0] inc_facet;
    logic                        ext;
    logic                        has;

    // this dimension's slice layout
    assign off_next = off_in + ccfg_pkg::OFF_W'(width_reg);
    assign off_p1   = off_in + 7'd1;

    // size register and derived slice width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= ccfg_pkg::SIZE_RST;
            width_reg <= ccfg_pkg::WIDTH_RST;
        end
        else if (cfg_wr.we)
        begin
            size_reg  <= cfg_wr.data;
            width_reg <= ccfg_pkg::slice_width(cfg_wr.data);
        end
    end

    // coordinate increment with wrap at the grid size
    always_comb
    begin
        sh    = in_item.code >> off_in;
        one_w = 17'd1 << (width_reg - 5'd1);
        coord = sh[16:1] & 16'(one_w - 17'd1);
        x     = {1'b0, coord} + 17'd1;
        sz    = {1'b0, size_reg};
        if (size_reg == '0)
        begin
            inc = '0;
        end
        else if (x >= sz)
        begin
            inc = 16'(x - sz);
        end
        else
        begin
            inc = x[15:0];
        end
    end

    // first facet: slice replaced by the wrapped coordinate, extent cleared
    always_comb
    begin
        wmask     = 17'((18'd1 << width_reg) - 18'd1);
        fmask     = {47'd0, wmask} << off_in;
        ins       = {48'd0, inc} << off_p1;
        inc_facet = (in_item.code & ~fmask) | (ins & fmask);
        ext       = (off_in < 7'd64) && in_item.code[off_in[5:0]];
        has       = dim_on && ext && (width_reg <= 5'(ccfg_pkg::MAX_SLICE));
    end

    // lanes handed on, this cell fills its own
    always_comb
    begin
        inc_next      = in_inc;
        inc_next[IDX] = inc_facet;
        has_next      = in_has;
        has_next[IDX] = has;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= '{code: in_item.code,
                          cnt:  in_item.cnt + ccfg_pkg::CNT_W'(dim_on && ext)};
            inc_reg  <= inc_next;
            has_reg  <= has_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_inc   = inc_reg;
    assign out_has   = has_reg;

endmodule

[rtl/ccfg_emit.sv]
`timescale 1ns / 1ps

module ccfg_emit #(
    parameter int MAX_DIMS = 4
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          tail_valid,
    input  ccfg_pkg::item_t                               tail_item,
    input  logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0]     tail_inc,
    input  logic [MAX_DIMS-1:0]                           tail_has,
    input  logic [MAX_DIMS-1:0][ccfg_pkg::OFF_W-1:0]      offs,
    output logic                                          tail_take,
    ccfg_if.source                                        facet_ch
);

    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic                  busy_reg, busy_next;
    logic                  vtx_reg, vtx_next;
    logic                  half_reg, half_next;
    logic [1:0]            pos_reg, pos_next;
    logic [MAX_DIMS-1:0]   pend_reg, pend_next;
    logic                  ov_reg, ov_next;

    logic [ccfg_pkg::CODE_W-1:0]               code_reg;
    logic [ccfg_pkg::CNT_W-1:0]                cnt_reg;
    logic [MAX_DIMS-1:0][ccfg_pkg::CODE_W-1:0] inc_reg;
    ccfg_pkg::facet_word_t                     ow_reg;
    ccfg_pkg::facet_word_t                     word;

    logic [DIW-1:0]              cur;
    logic                        found;
    logic [ccfg_pkg::CODE_W-1:0] plain;
    logic                        last_emit;
    logic                        out_load;
    logic                        step;
    logic                        finishing;

    // lowest dimension still owing facets
    always_comb
    begin
        cur   = '0;
        found = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (!found && pend_reg[i])
            begin
                cur   = DIW'(i);
                found = 1'b1;
            end
        end
    end

    // handshake with the output register and the row of cells
    always_comb
    begin
        last_emit = vtx_reg ||
                    (half_reg && ((pend_reg & ~(MAX_DIMS'(1) << cur)) == '0));
        out_load  = !ov_reg || facet_ch.ready;
        step      = busy_reg && out_load;
        finishing = step && last_emit;
        tail_take = tail_valid && (!busy_reg || finishing);
    end

    // result word
    always_comb
    begin
        plain               = code_reg & ~(64'd1 << offs[cur]);
        word.facet_code     = vtx_reg ? '0 : (half_reg ? plain : inc_reg[cur]);
        word.negative_sign  = !vtx_reg && (pos_reg == 2'd1 || pos_reg == 2'd2);
        word.cube_dimension = cnt_reg;
        word.no_facets      = vtx_reg;
        word.last           = last_emit;
    end

    // sequencing of the facets of one item
    always_comb
    begin
        busy_next = busy_reg;
        vtx_next  = vtx_reg;
        half_next = half_reg;
        pos_next  = pos_reg;
        pend_next = pend_reg;
        ov_next   = out_load ? step : ov_reg;
        if (step)
        begin
            pos_next  = pos_reg + 2'd1;
            half_next = !half_reg;
            if (half_reg)
            begin
                pend_next[cur] = 1'b0;
            end
        end
        if (finishing)
        begin
            busy_next = 1'b0;
        end
        if (tail_take)
        begin
            busy_next = (tail_item.cnt == '0) || (tail_has != '0);
            vtx_next  = (tail_item.cnt == '0);
            half_next = 1'b0;
            pos_next  = '0;
            pend_next = tail_has;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            vtx_reg  <= 1'b0;
            half_reg <= 1'b0;
            pos_reg  <= '0;
            pend_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            vtx_reg  <= vtx_next;
            half_reg <= half_next;
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    // item and output word payload
    always_ff @(posedge clk)
    begin
        if (tail_take)
        begin
            code_reg <= tail_item.code;
            cnt_reg  <= tail_item.cnt;
            inc_reg  <= tail_inc;
        end
        if (step)
        begin
            ow_reg <= word;
        end
    end

    assign facet_ch.valid = ov_reg;
    assign facet_ch.data  = ow_reg;

endmodule

[rtl/ccfg_checker.sv]
`timescale 1ns / 1ps

module ccfg_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  ccfg_pkg::facet_word_t out_word
);

    logic first_reg;

    // next accepted word opens a new cube
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            first_reg <= out_word.last;
        end
    end

    // stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("result word changed while stalled");

    // a vertex gives a single plain word
    a_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.no_facets |->
            out_word.last && out_word.cube_dimension == '0 && !out_word.negative_sign)
        else $error("vertex word malformed");

    // real facets come from a cube with at least one extent
    a_facet_dim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.no_facets |-> out_word.cube_dimension != '0)
        else $error("facet from a cube of dimension zero");

    // sign pattern restarts at plus for every cube
    a_first_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && first_reg |-> !out_word.negative_sign)
        else $error("first facet of a cube has minus sign");

endmodule

bind cubical_cube_facet_generator ccfg_checker u_ccfg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (facet_ch.valid),
    .out_ready (facet_ch.ready),
    .out_word  (facet_ch.data)
);

[dv/tb.sv]
`timescale 1ns / 1ps

// expected facet words and the register copy they are worked out from
class facet_scoreboard;
    int unsigned                 dims_reg;
    int unsigned                 size_reg[4];
    int unsigned                 slice_w[4];
    int unsigned                 slice_lo[4];
    ccfg_pkg::facet_word_t       expected_q[$];
    int unsigned                 errors;
    int unsigned                 checked;
    int unsigned                 vertices;

    function new();
        dims_reg = 32'(ccfg_pkg::DIMS_RST);
        foreach (size_reg[d])
            size_reg[d] = 32'(ccfg_pkg::SIZE_RST);
        errors   = 0;
        checked  = 0;
        vertices = 0;
        relayout();
    endfunction

    // slice width is the smallest k with 2^k >= size, plus the extent bit
    function void relayout();
        int unsigned lo;
        lo = 0;
        for (int d = 0; d < 4; d++)
        begin
            slice_w[d] = 17;
            for (int k = 15; k >= 0; k--)
                if ((32'd1 << k) >= size_reg[d])
                    slice_w[d] = k + 1;
            slice_lo[d] = lo;
            lo += slice_w[d];
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
        if (idx == ccfg_pkg::CFG_DIMS)
            dims_reg = 32'(data[2:0]);
        else if (idx - ccfg_pkg::CFG_SIZE0 < 4)
        begin
            size_reg[idx - ccfg_pkg::CFG_SIZE0] = 32'(data);
            relayout();
        end
    endfunction

    // facets of one accepted cube word, in emission order
    function void note_cube(logic [63:0] code);
        ccfg_pkg::facet_word_t burst[8];
        logic [63:0]           mask;
        logic [63:0]           field;
        logic [63:0]           coord;
        logic [63:0]           bump;
        logic [63:0]           modulus;
        logic [63:0]           pick;
        int unsigned           active;
        int unsigned           extents;
        int unsigned           n;
        active  = (dims_reg > 4) ? 4 : dims_reg;
        extents = 0;
        n       = 0;
        for (int d = 0; d < active; d++)
            if (slice_lo[d] < 64 && code[slice_lo[d]])
                extents++;
        if (extents == 0)
        begin
            burst[0] = '{facet_code: '0, negative_sign: 1'b0, cube_dimension: '0,
                         no_facets: 1'b1, last: 1'b1};
            n = 1;
            vertices++;
        end
        else
        begin
            for (int d = 0; d < active; d++)
            begin
                if (slice_lo[d] >= 64 || slice_w[d] > 16)
                    continue;
                mask  = ((64'd1 << slice_w[d]) - 64'd1) << slice_lo[d];
                field = (code & mask) >> slice_lo[d];
                if (!field[0])
                    continue;
                coord   = field >> 1;
                modulus = 64'(size_reg[d]);
                bump    = (modulus == 0) ? 64'd0 : (coord + 64'd1) % modulus;
                // incremented coordinate first, then the original one
                for (int h = 0; h < 2; h++)
                begin
                    pick = (h == 0) ? bump : coord;
                    burst[n].facet_code     = (code & ~mask)
                                            | ((pick << (slice_lo[d] + 1)) & mask);
                    burst[n].negative_sign  = (n % 4 == 1) || (n % 4 == 2);
                    burst[n].cube_dimension = 3'(extents);
                    burst[n].no_facets      = 1'b0;
                    burst[n].last           = 1'b0;
                    n++;
                end
            end
            // extents only in unusable slices give no words at all
            if (n > 0)
                burst[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
            expected_q = {expected_q, burst[i]};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    task check_facet(ccfg_pkg::facet_word_t got);
        ccfg_pkg::facet_word_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("facet word with nothing expected", got.facet_code, '0);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.facet_code !== want.facet_code)
            report_mismatch("facet_code", got.facet_code, want.facet_code);
        if (got.negative_sign !== want.negative_sign)
            report_mismatch("negative_sign", got.negative_sign, want.negative_sign);
        if (got.cube_dimension !== want.cube_dimension)
            report_mismatch("cube_dimension", got.cube_dimension, want.cube_dimension);
        if (got.no_facets !== want.no_facets)
            report_mismatch("no_facets", got.no_facets, want.no_facets);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask
endclass

module tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [ccfg_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [ccfg_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                steady;
    int unsigned                         cubes_sent;
    int unsigned                         settings_applied;
    int unsigned                         idle_cycles;
    facet_scoreboard                     sb;

    ccfg_if #(.T(ccfg_pkg::cube_word_t))  cube_ch ();
    ccfg_if #(.T(ccfg_pkg::facet_word_t)) facet_ch ();

    cubical_cube_facet_generator #(.MAX_DIMS(4)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cube_ch   (cube_ch),
        .facet_ch  (facet_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // offer one cube word after a random gap and hold it until taken
    task automatic send_cube(logic [63:0] code);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            cube_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cube_ch.valid <= 1'b1;
        cube_ch.data  <= code;
        @(posedge clk);
        while (!cube_ch.ready)
            @(posedge clk);
        sb.note_cube(code);
        cubes_sent++;
    endtask

    // wait until every expected facet word is back and the pipe is empty
    task automatic settle();
        cube_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all five registers back to back while idle
    task automatic apply_setting(logic [2:0] dims, logic [15:0] s0, logic [15:0] s1,
                                 logic [15:0] s2, logic [15:0] s3);
        logic [15:0] sizes[4];
        logic [15:0] dims_word;
        sizes     = '{s0, s1, s2, s3};
        dims_word = {13'($urandom), dims};
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= ccfg_pkg::CFG_DIMS;
        cfg_data  <= dims_word;
        @(posedge clk);
        sb.write_reg(ccfg_pkg::CFG_DIMS, dims_word);
        for (int d = 0; d < 4; d++)
        begin
            cfg_index <= ccfg_pkg::CFG_SIZE0 + ccfg_pkg::CFG_IDX_W'(d);
            cfg_data  <= sizes[d];
            @(posedge clk);
            sb.write_reg(ccfg_pkg::CFG_SIZE0 + ccfg_pkg::CFG_IDX_W'(d), sizes[d]);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // facet side: random stalls, check each word taken
    initial
    begin
        int unsigned gap;
        facet_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap != 0)
            begin
                facet_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            facet_ch.ready <= 1'b1;
            @(posedge clk);
            while (!facet_ch.valid)
                @(posedge clk);
            sb.check_facet(facet_ch.data);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (cube_ch.valid && cube_ch.ready) || (facet_ch.valid && facet_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("[cubical_cube_facet_generator] ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [63:0] code;
        logic [63:0] mask;
        logic [63:0] field;
        logic [63:0] coord;
        logic [2:0]  dims_pick;
        logic [15:0] sz[4];
        int unsigned choice;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= ccfg_pkg::CFG_DIMS;
        cfg_data         <= '0;
        cube_ch.valid    <= 1'b0;
        cube_ch.data     <= '0;
        steady           = 1'b0;
        cubes_sent       = 0;
        settings_applied = 0;
        idle_cycles      = 0;
        sb               = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset layout: two dimensions of size 16, five bits each
        send_cube(64'h0);
        send_cube('1);
        send_cube(64'h0000_0000_0000_001F);
        send_cube(64'h0000_0000_0000_0020);
        send_cube(64'hFFFF_FFFF_FFFF_FFDE);
        send_cube(64'h0000_0000_0000_01EF);

        // four full-width slices, coordinates at the top wrap to zero
        apply_setting(3'd4, 16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_cube('1);
        send_cube(64'h0);
        send_cube(64'h0001_0001_0001_0001);
        send_cube(64'hFFFE_FFFE_FFFE_FFFF);

        // no dimension in use: every cube is a vertex
        apply_setting(3'd0, 16'd16, 16'd16, 16'd16, 16'd16);
        send_cube('1);
        send_cube(64'h0000_0000_0000_001F);

        // dims saturating, size one, size zero, coordinates above size
        apply_setting(3'd7, 16'd1, 16'd0, 16'd3, 16'd5);
        send_cube('1);
        send_cube(64'h0);
        send_cube(64'h0000_0000_0000_0001);
        send_cube(64'hAAAA_AAAA_AAAA_A1FE);

        // random settings, mostly well-formed cubes with random content
        for (int p = 0; p < 10; p++)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 7)
                dims_pick = 3'($urandom_range(1, 4));
            else if (choice == 7)
                dims_pick = 3'd0;
            else
                dims_pick = 3'($urandom_range(5, 7));
            for (int d = 0; d < 4; d++)
            begin
                case ($urandom_range(0, 9))
                    0: sz[d] = 16'd1;
                    1: sz[d] = 16'd2;
                    2: sz[d] = 16'd0;
                    3: sz[d] = 16'd32768;
                    4: sz[d] = 16'd16;
                    5: sz[d] = 16'd17;
                    6: sz[d] = 16'($urandom_range(3, 40));
                    7: sz[d] = 16'($urandom_range(1, 1000));
                    default: sz[d] = 16'($urandom_range(1, 32768));
                endcase
            end
            apply_setting(dims_pick, sz[0], sz[1], sz[2], sz[3]);
            steady = (p % 3 == 2);
            repeat (33)
            begin
                code = {$urandom, $urandom};
                if ($urandom_range(0, 9) < 8)
                begin
                    for (int d = 0; d < 4; d++)
                    begin
                        if (sb.slice_w[d] > 16 || sb.slice_lo[d] >= 64)
                            continue;
                        mask = ((64'd1 << sb.slice_w[d]) - 64'd1) << sb.slice_lo[d];
                        case ($urandom_range(0, 3))
                            0: coord = (sb.size_reg[d] == 0) ? 64'd0
                                     : 64'(sb.size_reg[d] - 1);
                            1: coord = 64'd0;
                            2: coord = (sb.size_reg[d] == 0) ? 64'd0
                                     : 64'($urandom_range(0, sb.size_reg[d] - 1));
                            default: coord = {$urandom, $urandom};
                        endcase
                        field = {coord[62:0], ($urandom_range(0, 2) != 0)};
                        code  = (code & ~mask) | ((field << sb.slice_lo[d]) & mask);
                    end
                end
                send_cube(code);
            end
        end
        steady = 1'b0;
        settle();

        $display("covered %0d cube words over %0d register settings, dims 0 to 7, sizes 0 to 32768",
                 cubes_sent, settings_applied);
        $display("checked %0d facet words, %0d vertex results, %0d mismatches",
                 sb.checked, sb.vertices, sb.errors);
        if (sb.errors == 0)
            $display("[cubical_cube_facet_generator] OK");
        else
            $display("[cubical_cube_facet_generator] ERROR");
        $finish;
    end
endmodule
